FILE: hdl/circular_deque_with_search_assert.svh
// assertion macros for the circular deque checker
// depends on nothing; included by the checker file
`ifndef CIRCULAR_DEQUE_WITH_SEARCH_ASSERT_SVH
`define CIRCULAR_DEQUE_WITH_SEARCH_ASSERT_SVH

// same-cycle implication under reset
`define CDQ_ASSERT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdq assertion failed");

// next-cycle implication under reset
`define CDQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdq assertion failed");

`endif

FILE: hdl/cdq_pkg.sv
// shared types and constants for the circular deque with search
// no dependencies
package cdq_pkg;

  localparam int unsigned MaxResults = 16;
  localparam int unsigned MatchCntW  = 5;
  localparam int unsigned PosW       = 4;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned OpW        = 3;
  localparam int unsigned DataW      = 32;

  typedef enum logic [OpW-1:0] {
    OP_INS_REAR  = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_REAR  = 3'd3,
    OP_SEARCH    = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE    = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_MATCH   = 3'd3,
    ST_NOMATCH = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FLUSH
  } state_e;

endpackage

FILE: hdl/circular_deque_with_search.sv
// Double-ended queue of DEPTH signed 32-bit entries in a ring, with front/rear insert and
// delete and a value search. Inserts and deletes each produce one response in the output
// register. A search reads the ring one entry at a time through the single memory read port
// and one 32-bit comparator, stops after MaxResults matches and stalls while responses wait
// on out_ready_i; the input is held off until the search has handed over its final response.
// depends on cdq_pkg, cdq_ctrl and cdq_store
module circular_deque_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [cdq_pkg::OpW-1:0]            op_i,
  input  logic signed [cdq_pkg::DataW-1:0]   value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [cdq_pkg::StatusW-1:0]        status_o,
  output logic [cdq_pkg::PosW-1:0]           position_o,
  output logic                               last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                      we;
  logic [AW-1:0]             waddr, raddr;
  logic [cdq_pkg::DataW-1:0] wdata, rdata;

  cdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .position_o  (position_o),
    .last_o      (last_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  cdq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

FILE: hdl/cdq_store.sv
// entry memory of the deque: one write port, one registered read port
// depends on cdq_pkg for the data width
module cdq_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [cdq_pkg::DataW-1:0]  wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [cdq_pkg::DataW-1:0]  rdata_o
);

  logic [cdq_pkg::DataW-1:0] mem_q [DEPTH];
  logic [cdq_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/cdq_ctrl.sv
// sequencer of the deque: ring pointers, request decode, search scan with one comparator
// depends on cdq_pkg; drives the write and read ports of cdq_store
module cdq_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cdq_pkg::OpW-1:0]       op_i,
  input  logic [cdq_pkg::DataW-1:0]     value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cdq_pkg::StatusW-1:0]   status_o,
  output logic [cdq_pkg::PosW-1:0]      position_o,
  output logic                          last_o,
  output logic                          we_o,
  output logic [AW-1:0]                 waddr_o,
  output logic [cdq_pkg::DataW-1:0]     wdata_o,
  output logic [AW-1:0]                 raddr_o,
  input  logic [cdq_pkg::DataW-1:0]     rdata_i
);

  localparam int unsigned MW = cdq_pkg::MatchCntW;
  localparam int unsigned PW = cdq_pkg::PosW;
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);
  localparam logic [MW-1:0] MaxCnt   = MW'(cdq_pkg::MaxResults);

  cdq_pkg::state_e  state_q, state_d;
  logic [AW-1:0]    head_q, head_d, tail_q, tail_d, slot_q, slot_d;
  logic [CW-1:0]    count_q, count_d, idx_q, idx_d;
  logic [MW-1:0]    mcnt_q, mcnt_d;
  logic [cdq_pkg::DataW-1:0] key_q, key_d;
  logic             pend_valid_q, pend_valid_d;
  logic [PW-1:0]    pend_pos_q, pend_pos_d;
  logic             out_valid_q, out_valid_d;
  cdq_pkg::status_e status_q, status_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic             last_q, last_d;

  logic             out_free;
  logic             is_full, is_empty, hit, scan_end;
  logic [CW-1:0]    idx_inc;
  logic [MW-1:0]    mcnt_inc;
  logic [CW+PW-1:0] idx_ext;
  logic [PW-1:0]    cur_pos;
  logic [AW-1:0]    head_prev, tail_prev, head_next, tail_next, slot_next;

  assign out_free  = !out_valid_q || out_ready_i;
  assign is_full   = (count_q == FullCnt);
  assign is_empty  = (count_q == '0);
  assign hit       = (rdata_i == key_q);
  assign idx_inc   = idx_q + CW'(1);
  assign scan_end  = (idx_inc == count_q);
  assign mcnt_inc  = mcnt_q + MW'(1);
  assign idx_ext   = {{PW{1'b0}}, idx_q};
  assign cur_pos   = idx_ext[PW-1:0];
  assign head_prev = (head_q == '0) ? LastSlot : head_q - AW'(1);
  assign tail_prev = (tail_q == '0) ? LastSlot : tail_q - AW'(1);
  assign head_next = (head_q == LastSlot) ? '0 : head_q + AW'(1);
  assign tail_next = (tail_q == LastSlot) ? '0 : tail_q + AW'(1);
  assign slot_next = (slot_q == LastSlot) ? '0 : slot_q + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cdq_pkg::S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    idx_q      <= idx_d;
    mcnt_q     <= mcnt_d;
    key_q      <= key_d;
    pend_pos_q <= pend_pos_d;
    status_q   <= status_d;
    pos_q      <= pos_d;
    last_q     <= last_d;
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    slot_d       = slot_q;
    idx_d        = idx_q;
    mcnt_d       = mcnt_q;
    key_d        = key_q;
    pend_valid_d = pend_valid_q;
    pend_pos_d   = pend_pos_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    pos_d        = pos_q;
    last_d       = last_q;
    in_ready_o   = 1'b0;
    we_o         = 1'b0;
    waddr_o      = tail_q;
    wdata_o      = value_i;

    case (state_q)
      cdq_pkg::S_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          pos_d  = '0;
          last_d = 1'b1;
          case (cdq_pkg::op_e'(op_i))
            cdq_pkg::OP_INS_REAR: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                status_d = cdq_pkg::ST_FULL;
              end else begin
                status_d = cdq_pkg::ST_DONE;
                we_o     = 1'b1;
                waddr_o  = tail_q;
                tail_d   = tail_next;
                count_d  = count_q + CW'(1);
              end
            end
            cdq_pkg::OP_INS_FRONT: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                status_d = cdq_pkg::ST_FULL;
              end else begin
                status_d = cdq_pkg::ST_DONE;
                we_o     = 1'b1;
                waddr_o  = head_prev;
                head_d   = head_prev;
                count_d  = count_q + CW'(1);
              end
            end
            cdq_pkg::OP_DEL_FRONT: begin
              out_valid_d = 1'b1;
              if (is_empty) begin
                status_d = cdq_pkg::ST_EMPTY;
              end else begin
                status_d = cdq_pkg::ST_DONE;
                head_d   = head_next;
                count_d  = count_q - CW'(1);
              end
            end
            cdq_pkg::OP_DEL_REAR: begin
              out_valid_d = 1'b1;
              if (is_empty) begin
                status_d = cdq_pkg::ST_EMPTY;
              end else begin
                status_d = cdq_pkg::ST_DONE;
                tail_d   = tail_prev;
                count_d  = count_q - CW'(1);
              end
            end
            cdq_pkg::OP_SEARCH: begin
              if (is_empty) begin
                out_valid_d = 1'b1;
                status_d    = cdq_pkg::ST_EMPTY;
              end else begin
                key_d        = value_i;
                slot_d       = head_q;
                idx_d        = '0;
                mcnt_d       = '0;
                pend_valid_d = 1'b0;
                state_d      = cdq_pkg::S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      cdq_pkg::S_READ: begin
        state_d = cdq_pkg::S_CMP;
      end

      cdq_pkg::S_CMP: begin
        if (hit) begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              status_d    = cdq_pkg::ST_MATCH;
              pos_d       = pend_pos_q;
              last_d      = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_pos_d   = cur_pos;
            mcnt_d       = mcnt_inc;
            if (mcnt_inc == MaxCnt || scan_end) begin
              state_d = cdq_pkg::S_FLUSH;
            end else begin
              idx_d   = idx_inc;
              slot_d  = slot_next;
              state_d = cdq_pkg::S_READ;
            end
          end
        end else if (scan_end) begin
          state_d = cdq_pkg::S_FLUSH;
        end else begin
          idx_d   = idx_inc;
          slot_d  = slot_next;
          state_d = cdq_pkg::S_READ;
        end
      end

      cdq_pkg::S_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          last_d       = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = cdq_pkg::S_IDLE;
          if (pend_valid_q) begin
            status_d = cdq_pkg::ST_MATCH;
            pos_d    = pend_pos_q;
          end else begin
            status_d = cdq_pkg::ST_NOMATCH;
            pos_d    = '0;
          end
        end
      end

      default: begin
        state_d = cdq_pkg::S_IDLE;
      end
    endcase
  end

  assign raddr_o     = slot_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign position_o  = pos_q;
  assign last_o      = last_q;

endmodule

FILE: hdl/cdq_checker.sv
// port-level checks of the circular deque, bound to the top level
// depends on cdq_pkg and circular_deque_with_search_assert.svh
`include "circular_deque_with_search_assert.svh"

module cdq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [cdq_pkg::OpW-1:0]       op_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [cdq_pkg::StatusW-1:0]   status_o,
  input logic [cdq_pkg::PosW-1:0]      position_o,
  input logic                          last_o
);

  logic in_acc, non_search, out_stall, is_match;

  assign in_acc     = in_valid_i && in_ready_o;
  assign non_search = (op_i == cdq_pkg::OP_INS_REAR) || (op_i == cdq_pkg::OP_INS_FRONT) ||
                      (op_i == cdq_pkg::OP_DEL_FRONT) || (op_i == cdq_pkg::OP_DEL_REAR);
  assign out_stall  = out_valid_o && !out_ready_i;
  assign is_match   = (status_o == cdq_pkg::ST_MATCH);

  // a stalled response holds
  `CDQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(status_o) && $stable(position_o) && $stable(last_o))

  // queue edit requests answer in the next cycle
  `CDQ_ASSERT_NEXT(a_edit_resp, clk_i, rst_ni, in_acc && non_search, out_valid_o && last_o && !is_match)

  // only match responses carry a position or leave the request open
  `CDQ_ASSERT(a_pos_zero, clk_i, rst_ni, out_valid_o && !is_match, position_o == '0 && last_o)

  // no new request while an earlier one still has responses to come
  `CDQ_ASSERT(a_no_overlap, clk_i, rst_ni, out_valid_o && !last_o, !in_ready_o)

endmodule

bind circular_deque_with_search cdq_checker u_cdq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .position_o  (position_o),
  .last_o      (last_o)
);

FILE: tb/circular_deque_with_search_tb.sv
// self-checking testbench for circular_deque_with_search: directed and random requests
// are scored against a ring-buffer deque predictor held in a scoreboard class
// depends on cdq_pkg and the circular_deque_with_search rtl
module circular_deque_with_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 16;
  localparam int unsigned RandomItems = 285;
  localparam int unsigned HoldOffCycles = 100;
  localparam logic [cdq_pkg::OpW-1:0] OpUnknownLo = 3'd5;
  localparam logic [cdq_pkg::OpW-1:0] OpUnknownHi = 3'd7;

  typedef struct packed {
    cdq_pkg::status_e          status;
    logic [cdq_pkg::PosW-1:0]  position;
    logic                      last;
  } response_t;

  class deque_scoreboard;
    logic signed [cdq_pkg::DataW-1:0] ring [Depth];
    int unsigned head;
    int unsigned tail;
    int unsigned count;
    response_t pending [$];
    int unsigned mismatches;

    function void push(cdq_pkg::status_e status, logic [cdq_pkg::PosW-1:0] position,
                       logic last);
      response_t r;
      r.status = status;
      r.position = position;
      r.last = last;
      pending.push_back(r);
    endfunction

    function void note_request(logic [cdq_pkg::OpW-1:0] op,
                               logic signed [cdq_pkg::DataW-1:0] value);
      int unsigned slot;
      int unsigned hits;
      case (op)
        cdq_pkg::OP_INS_REAR: begin
          if (count == Depth) begin
            push(cdq_pkg::ST_FULL, '0, 1'b1);
          end else begin
            ring[tail] = value;
            tail = (tail + 1) % Depth;
            count++;
            push(cdq_pkg::ST_DONE, '0, 1'b1);
          end
        end
        cdq_pkg::OP_INS_FRONT: begin
          if (count == Depth) begin
            push(cdq_pkg::ST_FULL, '0, 1'b1);
          end else begin
            head = (head == 0) ? Depth - 1 : head - 1;
            ring[head] = value;
            count++;
            push(cdq_pkg::ST_DONE, '0, 1'b1);
          end
        end
        cdq_pkg::OP_DEL_FRONT: begin
          if (count == 0) begin
            push(cdq_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            head = (head + 1) % Depth;
            count--;
            push(cdq_pkg::ST_DONE, '0, 1'b1);
          end
        end
        cdq_pkg::OP_DEL_REAR: begin
          if (count == 0) begin
            push(cdq_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            tail = (tail == 0) ? Depth - 1 : tail - 1;
            count--;
            push(cdq_pkg::ST_DONE, '0, 1'b1);
          end
        end
        cdq_pkg::OP_SEARCH: begin
          if (count == 0) begin
            push(cdq_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            hits = 0;
            slot = head;
            for (int i = 0; i < count && hits < cdq_pkg::MaxResults; i++) begin
              if (ring[slot] == value) begin
                push(cdq_pkg::ST_MATCH, cdq_pkg::PosW'(i), 1'b0);
                hits++;
              end
              slot = (slot + 1) % Depth;
            end
            if (hits == 0) begin
              push(cdq_pkg::ST_NOMATCH, '0, 1'b1);
            end else begin
              pending[pending.size() - 1].last = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_response(logic [cdq_pkg::StatusW-1:0] status,
                                 logic [cdq_pkg::PosW-1:0] position, logic last);
      response_t want;
      if (pending.size() == 0) begin
        $error("unexpected response: status %0d position %0d last %0d",
               status, position, last);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
      if (position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, position);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic [cdq_pkg::OpW-1:0]           op_i;
  logic signed [cdq_pkg::DataW-1:0]  value_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic [cdq_pkg::StatusW-1:0]       status_o;
  logic [cdq_pkg::PosW-1:0]          position_o;
  logic                              last_o;

  deque_scoreboard sb = new;
  bit no_idle;
  int unsigned hold_off_asked;
  int unsigned hold_off_taken;
  int unsigned hold_left;

  circular_deque_with_search #(
    .DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .position_o (position_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = '0;
    value_i = '0;
    out_ready_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_response(status_o, position_o, last_o);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_off_taken != hold_off_asked) begin
        hold_off_taken = hold_off_asked;
        hold_left = HoldOffCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  task automatic send_request(logic [cdq_pkg::OpW-1:0] op,
                              logic signed [cdq_pkg::DataW-1:0] value);
    while (!no_idle && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    value_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(op, value);
  endtask

  function automatic logic signed [cdq_pkg::DataW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 3);
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'hffff_ffff;
        default: return 32'h0;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [cdq_pkg::OpW-1:0] pick_op(int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return cdq_pkg::OpW'($urandom_range(OpUnknownLo, OpUnknownHi));
    case (mode)
      0: begin
        if (r < 60) begin
          return ($urandom_range(0, 1) != 0) ? cdq_pkg::OP_INS_FRONT : cdq_pkg::OP_INS_REAR;
        end
        if (r < 80) return cdq_pkg::OP_SEARCH;
        return ($urandom_range(0, 1) != 0) ? cdq_pkg::OP_DEL_FRONT : cdq_pkg::OP_DEL_REAR;
      end
      1: begin
        if (r < 60) begin
          return ($urandom_range(0, 1) != 0) ? cdq_pkg::OP_DEL_FRONT : cdq_pkg::OP_DEL_REAR;
        end
        if (r < 80) return cdq_pkg::OP_SEARCH;
        return ($urandom_range(0, 1) != 0) ? cdq_pkg::OP_INS_FRONT : cdq_pkg::OP_INS_REAR;
      end
      2: return cdq_pkg::OpW'($urandom_range(cdq_pkg::OP_INS_REAR, cdq_pkg::OP_SEARCH));
      default: begin
        if (r < 60) return cdq_pkg::OP_SEARCH;
        return cdq_pkg::OpW'($urandom_range(cdq_pkg::OP_INS_REAR, cdq_pkg::OP_DEL_REAR));
      end
    endcase
  endfunction

  initial begin
    int unsigned issued;
    int unsigned mode;
    bit held;
    logic [cdq_pkg::OpW-1:0] op;
    logic signed [cdq_pkg::DataW-1:0] common;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, unknown op, extremes, wraparound, full, multi-match
    send_request(cdq_pkg::OP_SEARCH, 32'h0);
    send_request(cdq_pkg::OP_DEL_FRONT, 32'h0);
    send_request(cdq_pkg::OP_DEL_REAR, 32'h0);
    send_request(OpUnknownHi, 32'hffff_ffff);
    send_request(cdq_pkg::OP_INS_REAR, 32'h7fff_ffff);
    send_request(cdq_pkg::OP_INS_FRONT, 32'h8000_0000);
    send_request(cdq_pkg::OP_SEARCH, 32'h7fff_ffff);
    send_request(cdq_pkg::OP_SEARCH, 32'h8000_0000);
    for (int i = 0; i < Depth - 2; i++) begin
      send_request((i % 2 == 0) ? cdq_pkg::OP_INS_FRONT : cdq_pkg::OP_INS_REAR,
                   32'hffff_ffff);
    end
    send_request(cdq_pkg::OP_INS_REAR, 32'h0);
    send_request(cdq_pkg::OP_INS_FRONT, 32'h0);
    send_request(cdq_pkg::OP_SEARCH, 32'hffff_ffff);
    send_request(cdq_pkg::OP_SEARCH, 32'h1);
    send_request(cdq_pkg::OP_DEL_FRONT, 32'h0);
    send_request(cdq_pkg::OP_DEL_REAR, 32'h0);

    issued = 0;
    held = 0;
    while (issued < RandomItems) begin
      mode = $urandom_range(0, 4);
      if (mode == 4) begin
        common = pick_value();
        for (int i = 0; i < Depth; i++) begin
          send_request(($urandom_range(0, 1) != 0) ? cdq_pkg::OP_INS_FRONT
                                                   : cdq_pkg::OP_INS_REAR, common);
        end
        send_request(cdq_pkg::OP_SEARCH, common);
        issued += Depth + 1;
      end else begin
        repeat ($urandom_range(8, 24)) begin
          op = pick_op(mode);
          send_request(op, pick_value());
          if (op <= cdq_pkg::OP_SEARCH) issued++;
          no_idle = (issued >= 120 && issued < 190);
          if (!held && issued >= 150) begin
            held = 1;
            hold_off_asked++;
          end
        end
      end
    end
    in_valid_i <= 1'b0;
    no_idle = 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
